@@ rtl/hdw_pkg.sv @@
// ---------------------------------------------------------------------------
// hdw_pkg
// Shared types and constants for the Huffman tree-walk decoder.
// ---------------------------------------------------------------------------
package hdw_pkg;

  // Tree shape
  localparam int HDW_INTERNAL_NODES = 256;
  localparam int HDW_ID_W           = 9;
  localparam int HDW_SLOT_W         = 8;
  localparam int HDW_SYM_W          = 8;
  localparam int HDW_BYTE_W         = 8;
  localparam int HDW_CNT_W          = 32;
  localparam int HDW_BITCNT_W       = 3;

  // Configuration port
  localparam int HDW_CFG_DATA_W = 32;
  localparam int HDW_CFG_IDX_W  = 1;
  localparam logic [HDW_CFG_IDX_W-1:0] CFG_ROOT_NODE    = 1'b0;
  localparam logic [HDW_CFG_IDX_W-1:0] CFG_SYMBOL_TOTAL = 1'b1;

  // Request codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  localparam logic [HDW_ID_W-1:0]     RESET_ROOT   = 9'd511;
  localparam logic [HDW_BITCNT_W-1:0] LAST_BIT_IDX = 3'd7;

  // Input item
  typedef struct packed {
    logic                  req_type;
    logic [HDW_SLOT_W-1:0] node_slot;
    logic [HDW_ID_W-1:0]   left_child;
    logic [HDW_ID_W-1:0]   right_child;
    logic [HDW_BYTE_W-1:0] data_byte;
  } hdw_in_t;

  // Result item
  typedef struct packed {
    logic [HDW_SYM_W-1:0] symbol;
    logic                 last;
  } hdw_out_t;

  // Walk sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } hdw_state_t;

  // Requests from the walk sequencer to the output buffer
  typedef struct packed {
    logic                 emit;
    logic                 flush;
    logic [HDW_SYM_W-1:0] symbol;
  } hdw_obuf_req_t;

  // Status from the output buffer
  typedef struct packed {
    logic can_emit;
    logic can_flush;
    logic pend_valid;
  } hdw_obuf_stat_t;

endpackage

@@ rtl/hdw_node_store.sv @@
// ---------------------------------------------------------------------------
// hdw_node_store
// Left and right child memories, one write port and one registered read port.
// ---------------------------------------------------------------------------
module hdw_node_store #(
  parameter int INTERNAL_NODES = hdw_pkg::HDW_INTERNAL_NODES
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [hdw_pkg::HDW_SLOT_W-1:0] wr_slot,
  input  logic [hdw_pkg::HDW_ID_W-1:0]   wr_left,
  input  logic [hdw_pkg::HDW_ID_W-1:0]   wr_right,
  input  logic                          rd_en,
  input  logic [hdw_pkg::HDW_SLOT_W-1:0] rd_slot,
  output logic [hdw_pkg::HDW_ID_W-1:0]   rd_left,
  output logic [hdw_pkg::HDW_ID_W-1:0]   rd_right
);
  import hdw_pkg::*;

  localparam int AW = (INTERNAL_NODES > 1) ? $clog2(INTERNAL_NODES) : 1;
  localparam logic [HDW_SLOT_W:0] SLOT_LIMIT = (HDW_SLOT_W+1)'(INTERNAL_NODES);

  logic [HDW_ID_W-1:0] left_mem  [INTERNAL_NODES];
  logic [HDW_ID_W-1:0] right_mem [INTERNAL_NODES];

  logic [HDW_ID_W-1:0] left_q_r;
  logic [HDW_ID_W-1:0] right_q_r;
  logic                oob_r;

  logic wr_in_range;
  logic rd_in_range;

  assign wr_in_range = {1'b0, wr_slot} < SLOT_LIMIT;
  assign rd_in_range = {1'b0, rd_slot} < SLOT_LIMIT;

  // Write port: slots past the node count are dropped
  always_ff @(posedge clk) begin
    if (wr_en && wr_in_range) begin
      left_mem[wr_slot[AW-1:0]]  <= wr_left;
      right_mem[wr_slot[AW-1:0]] <= wr_right;
    end
  end

  // Registered read; output holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      left_q_r  <= left_mem[rd_slot[AW-1:0]];
      right_q_r <= right_mem[rd_slot[AW-1:0]];
      oob_r     <= !rd_in_range;
    end
  end

  // Missing slots read as a leaf with symbol zero
  assign rd_left  = oob_r ? '0 : left_q_r;
  assign rd_right = oob_r ? '0 : right_q_r;

endmodule

@@ rtl/hdw_out_buf.sv @@
// ---------------------------------------------------------------------------
// hdw_out_buf
// Holds the newest symbol until the next one or the end of the byte tells
// whether it is the last, plus the output register toward the sink.
// ---------------------------------------------------------------------------
module hdw_out_buf (
  input  logic                    clk,
  input  logic                    rst_n,
  input  hdw_pkg::hdw_obuf_req_t  req,
  output hdw_pkg::hdw_obuf_stat_t stat,
  output logic                    out_valid,
  input  logic                    out_stall,
  output hdw_pkg::hdw_out_t       out_data
);
  import hdw_pkg::*;

  logic                 pend_valid_r, pend_valid_nxt;
  logic [HDW_SYM_W-1:0] pend_sym_r, pend_sym_nxt;
  logic                 out_valid_r, out_valid_nxt;
  hdw_out_t             out_data_r, out_data_nxt;
  logic                 out_free;

  // Output register is free when empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;

  assign stat.can_emit   = !pend_valid_r || out_free;
  assign stat.can_flush  = !pend_valid_r || out_free;
  assign stat.pend_valid = pend_valid_r;

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_sym_nxt   = pend_sym_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    if (req.emit) begin
      // older symbol is known not to be last
      if (pend_valid_r) begin
        out_valid_nxt       = 1'b1;
        out_data_nxt.symbol = pend_sym_r;
        out_data_nxt.last   = 1'b0;
      end
      pend_valid_nxt = 1'b1;
      pend_sym_nxt   = req.symbol;
    end else if (req.flush && pend_valid_r && out_free) begin
      out_valid_nxt       = 1'b1;
      out_data_nxt.symbol = pend_sym_r;
      out_data_nxt.last   = 1'b1;
      pend_valid_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_sym_r <= pend_sym_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/huffman_tree_walk_decoder.sv @@
// ---------------------------------------------------------------------------
// huffman_tree_walk_decoder
// Huffman decoder that walks a stored code tree one bit per cycle unless a stalled sink holds it.
//
//   channel  direction  handshake               payload
//   in_      input      in_valid / in_stall     hdw_in_t  (load or decode)
//   out_     output     out_valid / out_stall   hdw_out_t (symbol, last)
//   cfg_     input      cfg_wr_en               cfg_index, cfg_wdata
//
// A load item is taken without leaving idle. A decode item runs as follows:
// the idle state starts the first child read, then eight tree steps (one
// registered child-memory read per bit, each address taken from the
// previous read), then the flush state releases the held last symbol.
// Reset is synchronous; the child memories are not cleared.
// A stalled sink pauses the walk only when a symbol has to move on.
// ---------------------------------------------------------------------------
module huffman_tree_walk_decoder #(
  parameter int INTERNAL_NODES = hdw_pkg::HDW_INTERNAL_NODES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  hdw_pkg::hdw_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output hdw_pkg::hdw_out_t                  out_data,
  input  logic                               cfg_wr_en,
  input  logic [hdw_pkg::HDW_CFG_IDX_W-1:0]  cfg_index,
  input  logic [hdw_pkg::HDW_CFG_DATA_W-1:0] cfg_wdata
);
  import hdw_pkg::*;

  hdw_state_t state_r, state_nxt;

  logic [HDW_ID_W-1:0]     root_r, root_nxt;
  logic [HDW_CNT_W-1:0]    total_r, total_nxt;
  logic [HDW_ID_W-1:0]     walk_node_r, walk_node_nxt;
  logic [HDW_CNT_W-1:0]    emit_cnt_r, emit_cnt_nxt;
  logic [HDW_BYTE_W-1:0]   shift_r, shift_nxt;
  logic [HDW_BITCNT_W-1:0] bit_cnt_r, bit_cnt_nxt;

  logic                  in_fire;
  logic                  rd_en;
  logic [HDW_SLOT_W-1:0] rd_slot;
  logic [HDW_ID_W-1:0]   rd_left;
  logic [HDW_ID_W-1:0]   rd_right;

  logic [HDW_ID_W-1:0] child;
  logic                is_leaf;
  logic                emit_want;
  logic                step_go;
  logic [HDW_ID_W-1:0] next_node;

  hdw_obuf_req_t  obuf_req;
  hdw_obuf_stat_t obuf_stat;

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;

  // Tree step: pick a child by the current bit, leaves go back to the root
  assign child     = shift_r[HDW_BYTE_W-1] ? rd_right : rd_left;
  assign is_leaf   = !child[HDW_ID_W-1];
  assign emit_want = is_leaf && (emit_cnt_r < total_r);
  assign step_go   = (state_r == ST_WALK) && (!emit_want || obuf_stat.can_emit);
  assign next_node = is_leaf ? root_r : child;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    root_nxt      = root_r;
    total_nxt     = total_r;
    walk_node_nxt = walk_node_r;
    emit_cnt_nxt  = emit_cnt_r;
    shift_nxt     = shift_r;
    bit_cnt_nxt   = bit_cnt_r;
    rd_en         = 1'b0;
    rd_slot       = walk_node_r[HDW_SLOT_W-1:0];
    obuf_req      = '0;
    obuf_req.symbol = child[HDW_SYM_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.req_type == REQ_LOAD) begin
            walk_node_nxt = root_r;
            emit_cnt_nxt  = '0;
          end else begin
            rd_en       = 1'b1;
            shift_nxt   = in_data.data_byte;
            bit_cnt_nxt = '0;
            state_nxt   = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (step_go) begin
          walk_node_nxt = next_node;
          shift_nxt     = {shift_r[HDW_BYTE_W-2:0], 1'b0};
          bit_cnt_nxt   = bit_cnt_r + 1'b1;
          obuf_req.emit = emit_want;
          if (emit_want) begin
            emit_cnt_nxt = emit_cnt_r + 1'b1;
          end
          if (bit_cnt_r == LAST_BIT_IDX) begin
            state_nxt = ST_FLUSH;
          end else begin
            rd_en   = 1'b1;
            rd_slot = next_node[HDW_SLOT_W-1:0];
          end
        end
      end
      ST_FLUSH: begin
        obuf_req.flush = 1'b1;
        if (obuf_stat.can_flush) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // Register writes; expected only while no item is in flight
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ROOT_NODE: begin
          root_nxt      = cfg_wdata[HDW_ID_W-1:0];
          walk_node_nxt = cfg_wdata[HDW_ID_W-1:0];
        end
        CFG_SYMBOL_TOTAL: total_nxt = cfg_wdata[HDW_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      root_r      <= RESET_ROOT;
      total_r     <= '0;
      walk_node_r <= RESET_ROOT;
      emit_cnt_r  <= '0;
      bit_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      root_r      <= root_nxt;
      total_r     <= total_nxt;
      walk_node_r <= walk_node_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
  end

  hdw_node_store #(
    .INTERNAL_NODES(INTERNAL_NODES)
  ) u_store (
    .clk      (clk),
    .wr_en    (in_fire && (in_data.req_type == REQ_LOAD)),
    .wr_slot  (in_data.node_slot),
    .wr_left  (in_data.left_child),
    .wr_right (in_data.right_child),
    .rd_en    (rd_en),
    .rd_slot  (rd_slot),
    .rd_left  (rd_left),
    .rd_right (rd_right)
  );

  hdw_out_buf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (obuf_req),
    .stat      (obuf_stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // No symbol may be held over while the block is idle
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !obuf_stat.pend_valid)
    else $error("symbol held while idle");

  // The eighth tree step always ends the walk
  a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (step_go && bit_cnt_r == LAST_BIT_IDX) |=> (state_r == ST_FLUSH))
    else $error("walk did not end after eighth bit");

  // A paused walk keeps its bits
  a_pause_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && !step_go) |=> $stable(shift_r) && $stable(bit_cnt_r))
    else $error("walk state moved while paused");
`endif

endmodule
